FILE: hw/rtl/cfbq_pkg.sv
// shared types, constants and microcode for the cubic feedback biquad filter
package cfbq_pkg;

  localparam int SAMPLE_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF    = 28;
  localparam int NEWTON_STEPS_DEF = 3;

  // internal word and saturation limit (2^62 - 1)
  localparam int IW = 64;
  localparam int AW = 128;
  localparam logic signed [IW-1:0] LIM = 64'sh3fff_ffff_ffff_ffff;

  localparam int PC_W = 5;
  localparam logic [PC_W-1:0] LOOP_PC = 5'd12;
  localparam logic [PC_W-1:0] LAST_PC = 5'd21;

  localparam int NUM_COEF = 6;

  typedef enum logic [2:0] {
    REG_B0   = 3'd0,
    REG_B1   = 3'd1,
    REG_B2   = 3'd2,
    REG_A1   = 3'd3,
    REG_A2   = 3'd4,
    REG_EPS  = 3'd5,
    REG_MASK = 3'd6,
    REG_NONE = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV} op_t;

  typedef enum logic [4:0] {
    SRC_ZERO, SRC_ONE, SRC_C0, SRC_C1, SRC_C2, SRC_C3, SRC_C4, SRC_EPS, SRC_X0,
    SRC_P1, SRC_P2, SRC_Q1, SRC_Q2,
    SRC_S, SRC_T, SRC_RHS, SRC_U, SRC_E, SRC_F, SRC_D
  } src_t;

  typedef enum logic [2:0] {DST_S, DST_T, DST_RHS, DST_U, DST_E, DST_F, DST_D} dst_t;

  typedef struct packed {
    op_t  op;
    src_t a;
    src_t b;
    dst_t dst;
  } uop_t;

  typedef enum logic [2:0] {ST_IDLE, ST_ISSUE, ST_MWAIT, ST_DWAIT, ST_FINISH} state_t;

  // biquad target, rhs, then one newton step (repeated from LOOP_PC)
  function automatic uop_t uop_at(input logic [PC_W-1:0] pc);
    uop_t u;
    u = '{OP_ADD, SRC_ZERO, SRC_ZERO, DST_T};
    unique case (pc)
      5'd0:  u = '{OP_MUL, SRC_C0,  SRC_X0,   DST_S};
      5'd1:  u = '{OP_MUL, SRC_C1,  SRC_P1,   DST_T};
      5'd2:  u = '{OP_ADD, SRC_S,   SRC_T,    DST_S};
      5'd3:  u = '{OP_MUL, SRC_C2,  SRC_P2,   DST_T};
      5'd4:  u = '{OP_ADD, SRC_S,   SRC_T,    DST_S};
      5'd5:  u = '{OP_MUL, SRC_C3,  SRC_Q1,   DST_T};
      5'd6:  u = '{OP_SUB, SRC_S,   SRC_T,    DST_S};
      5'd7:  u = '{OP_MUL, SRC_C4,  SRC_Q2,   DST_T};
      5'd8:  u = '{OP_SUB, SRC_S,   SRC_T,    DST_S};
      5'd9:  u = '{OP_ADD, SRC_EPS, SRC_ONE,  DST_T};
      5'd10: u = '{OP_MUL, SRC_T,   SRC_S,    DST_RHS};
      5'd11: u = '{OP_ADD, SRC_S,   SRC_ZERO, DST_U};
      5'd12: u = '{OP_MUL, SRC_U,   SRC_U,    DST_T};
      5'd13: u = '{OP_MUL, SRC_EPS, SRC_T,    DST_E};
      5'd14: u = '{OP_MUL, SRC_E,   SRC_U,    DST_T};
      5'd15: u = '{OP_ADD, SRC_U,   SRC_T,    DST_F};
      5'd16: u = '{OP_SUB, SRC_F,   SRC_RHS,  DST_F};
      5'd17: u = '{OP_ADD, SRC_ONE, SRC_E,    DST_D};
      5'd18: u = '{OP_ADD, SRC_D,   SRC_E,    DST_D};
      5'd19: u = '{OP_ADD, SRC_D,   SRC_E,    DST_D};
      5'd20: u = '{OP_DIV, SRC_F,   SRC_D,    DST_T};
      5'd21: u = '{OP_SUB, SRC_U,   SRC_T,    DST_U};
      default: u = '{OP_ADD, SRC_ZERO, SRC_ZERO, DST_T};
    endcase
    return u;
  endfunction

endpackage

FILE: hw/rtl/cfbq_mul.sv
// iterative fixed-point multiplier: four 32x32 partial products, floor shift, saturate
module cfbq_mul
  import cfbq_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [IW-1:0] a,
  input  logic signed [IW-1:0] b,
  output logic                 done,
  output logic signed [IW-1:0] res
);

  localparam logic [AW-1:0] FMASK = (128'd1 << FRAC_BITS) - 128'd1;

  logic [62:0]          ua_r, ub_r;
  logic                 neg_r;
  logic [2:0]           cnt_r;
  logic                 run_r;
  logic [63:0]          pp_r;
  logic [1:0]           psh_r;
  logic                 pv_r;
  logic [AW-1:0]        acc_r;
  logic                 done_r;
  logic signed [IW-1:0] res_r;

  logic [IW-1:0]        na, nb;
  logic [31:0]          pa, pb;
  logic [AW-1:0]        qf;
  logic                 ovf, rem_nz;
  logic [62:0]          q1;
  logic signed [IW-1:0] fin;

  assign na = a[IW-1] ? (~a + 64'd1) : a;
  assign nb = b[IW-1] ? (~b + 64'd1) : b;
  assign pa = cnt_r[0] ? {1'b0, ua_r[62:32]} : ua_r[31:0];
  assign pb = cnt_r[1] ? {1'b0, ub_r[62:32]} : ub_r[31:0];

  always_comb begin
    qf     = acc_r >> FRAC_BITS;
    ovf    = |qf[AW-1:62];
    rem_nz = |(acc_r & FMASK);
    q1     = {1'b0, qf[61:0]} + {62'd0, rem_nz};
    if (ovf) begin
      fin = neg_r ? -LIM : LIM;
    end else if (neg_r) begin
      fin = q1[62] ? -LIM : -$signed({1'b0, q1});
    end else begin
      fin = $signed({2'b00, qf[61:0]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      pv_r   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        ua_r  <= na[62:0];
        ub_r  <= nb[62:0];
        neg_r <= a[IW-1] ^ b[IW-1];
        acc_r <= '0;
        cnt_r <= '0;
        pv_r  <= 1'b0;
        run_r <= 1'b1;
      end else if (run_r) begin
        if (cnt_r < 3'd4) begin
          pp_r  <= pa * pb;
          psh_r <= {1'b0, cnt_r[0]} + {1'b0, cnt_r[1]};
          pv_r  <= 1'b1;
        end else begin
          pv_r <= 1'b0;
        end
        if (pv_r) begin
          acc_r <= acc_r + ({64'd0, pp_r} << {psh_r, 5'd0});
        end
        if (cnt_r == 3'd5) begin
          res_r  <= fin;
          done_r <= 1'b1;
          run_r  <= 1'b0;
        end
        cnt_r <= cnt_r + 3'd1;
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

FILE: hw/rtl/cfbq_div.sv
// iterative fixed-point divider: restoring, one quotient bit a cycle, truncate and saturate
module cfbq_div
  import cfbq_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [IW-1:0] n,
  input  logic signed [IW-1:0] d,
  output logic                 done,
  output logic signed [IW-1:0] res
);

  logic [63:0]          rem_r;
  logic [AW-1:0]        dv_r;
  logic [63:0]          q_r;
  logic [62:0]          ud_r;
  logic                 neg_r;
  logic [7:0]           cnt_r;
  logic                 ovf_r;
  logic                 run_r;
  logic                 fin_r;
  logic                 done_r;
  logic signed [IW-1:0] res_r;

  logic [IW-1:0] nn, nd;
  logic [64:0]   r2;
  logic          ge;
  logic [64:0]   rsub;
  logic [IW-1:0] qs;

  assign nn   = n[IW-1] ? (~n + 64'd1) : n;
  assign nd   = d[IW-1] ? (~d + 64'd1) : d;
  assign r2   = {rem_r, dv_r[AW-1]};
  assign ge   = r2 >= {2'b00, ud_r};
  assign rsub = r2 - {2'b00, ud_r};
  assign qs   = (ovf_r || q_r[63] || q_r[62]) ? LIM : q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      fin_r  <= 1'b0;
      if (start) begin
        if (d == '0) begin
          // zero denominator leaves u unchanged: subtract nothing
          res_r  <= '0;
          done_r <= 1'b1;
        end else begin
          ud_r  <= nd[62:0];
          neg_r <= n[IW-1] ^ d[IW-1];
          dv_r  <= {64'd0, nn} << FRAC_BITS;
          rem_r <= '0;
          q_r   <= '0;
          ovf_r <= 1'b0;
          cnt_r <= 8'd128;
          run_r <= 1'b1;
        end
      end else if (run_r) begin
        rem_r <= ge ? rsub[63:0] : r2[63:0];
        dv_r  <= dv_r << 1;
        q_r   <= {q_r[62:0], ge};
        if (ge && cnt_r >= 8'd64) begin
          ovf_r <= 1'b1;
        end
        cnt_r <= cnt_r - 8'd1;
        if (cnt_r == 8'd1) begin
          run_r <= 1'b0;
          fin_r <= 1'b1;
        end
      end else if (fin_r) begin
        res_r  <= neg_r ? -$signed(qs) : $signed(qs);
        done_r <= 1'b1;
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

FILE: hw/rtl/cubic_feedback_biquad_filter_core.sv
// cubic feedback biquad filter: sequencer, operand file, config registers, history
// per input word: 15 multiplies on the shared 32x32 multiplier, NEWTON_STEPS divides
// on the bit-serial divider, 24 adds/subtracts and one finish state
// a new word is taken only after the last is finished: in_ready is high only while idle,
// and a finished word waits in the output register; synchronous active-low reset clears
// history and config, but sets coefficient b0 to one
module cubic_feedback_biquad_filter_core
  import cfbq_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int NEWTON_STEPS = NEWTON_STEPS_DEF,
  localparam int DATA_W      = (SAMPLE_WIDTH > 32) ? 64 : 32,
  localparam int ADDR_W      = (SAMPLE_WIDTH > 32) ? 6 : 5
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  logic signed [SAMPLE_WIDTH-1:0] sig_b0,
  input  logic signed [SAMPLE_WIDTH-1:0] sig_b1,
  input  logic signed [SAMPLE_WIDTH-1:0] sig_b2,
  input  logic signed [SAMPLE_WIDTH-1:0] sig_a1,
  input  logic signed [SAMPLE_WIDTH-1:0] sig_a2,
  input  logic signed [SAMPLE_WIDTH-1:0] sig_eps,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] out_sample,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [ADDR_W-1:0]              cfg_paddr,
  input  logic [DATA_W-1:0]              cfg_pwdata,
  output logic [DATA_W-1:0]              cfg_prdata,
  output logic                           cfg_pready
);

  localparam int ITER_W = (NEWTON_STEPS > 1) ? $clog2(NEWTON_STEPS) : 1;
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(NEWTON_STEPS - 1);
  localparam logic signed [IW-1:0] ONE = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [IW-1:0] OUT_HI = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1;
  localparam logic signed [IW-1:0] OUT_LO = -OUT_HI - 64'sd1;
  localparam int SH = (DATA_W == 64) ? 3 : 2;

  // config registers
  logic signed [SAMPLE_WIDTH-1:0] coef_r [NUM_COEF];
  logic [5:0]                     mask_r;
  reg_idx_t                       widx;
  logic                           cfg_wr;

  // per-word operands and history
  logic signed [SAMPLE_WIDTH-1:0] c_r [NUM_COEF];
  logic signed [SAMPLE_WIDTH-1:0] x0_r, p1_r, p2_r, q1_r, q2_r;
  logic signed [IW-1:0]           s_r, t_r, rhs_r, u_r, e_r, f_r, d_r;

  state_t              state_r, state_nxt;
  logic [PC_W-1:0]     pc_r, pc_nxt;
  logic [ITER_W-1:0]   iter_r, iter_nxt;
  logic                out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] out_r;

  uop_t                 uop;
  logic signed [IW-1:0] opa, opb;
  logic signed [64:0]   sum;
  logic signed [IW-1:0] alu_res;
  logic                 mul_start, div_start, mul_done, div_done;
  logic signed [IW-1:0] mul_res, div_res;
  logic                 wr_en;
  logic signed [IW-1:0] wr_val;
  logic                 take_in, emit;
  logic signed [SAMPLE_WIDTH-1:0] u_sat;

  assign widx   = reg_idx_t'(cfg_paddr[SH+2:SH]);
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  always_comb begin
    cfg_prdata = '0;
    unique case (widx)
      REG_B0, REG_B1, REG_B2, REG_A1, REG_A2, REG_EPS:
        cfg_prdata = DATA_W'($unsigned(coef_r[widx]));
      REG_MASK: cfg_prdata = DATA_W'(mask_r);
      default:  cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k < NUM_COEF; k++) begin
        coef_r[k] <= '0;
      end
      coef_r[0] <= SAMPLE_WIDTH'(ONE);
      mask_r    <= '0;
    end else if (cfg_wr) begin
      if (widx == REG_MASK) begin
        mask_r <= cfg_pwdata[5:0];
      end else if (widx != REG_NONE) begin
        coef_r[widx] <= cfg_pwdata[SAMPLE_WIDTH-1:0];
      end
    end
  end

  function automatic logic signed [IW-1:0] sx(input logic signed [SAMPLE_WIDTH-1:0] v);
    return IW'(v);
  endfunction

  always_comb begin
    uop = uop_at(pc_r);
    opa = '0;
    opb = '0;
    for (int k = 0; k < 2; k++) begin
      logic signed [IW-1:0] v;
      src_t sel;
      sel = (k == 0) ? uop.a : uop.b;
      case (sel)
        SRC_ZERO: v = '0;
        SRC_ONE:  v = ONE;
        SRC_C0:   v = sx(c_r[0]);
        SRC_C1:   v = sx(c_r[1]);
        SRC_C2:   v = sx(c_r[2]);
        SRC_C3:   v = sx(c_r[3]);
        SRC_C4:   v = sx(c_r[4]);
        SRC_EPS:  v = sx(c_r[5]);
        SRC_X0:   v = sx(x0_r);
        SRC_P1:   v = sx(p1_r);
        SRC_P2:   v = sx(p2_r);
        SRC_Q1:   v = sx(q1_r);
        SRC_Q2:   v = sx(q2_r);
        SRC_S:    v = s_r;
        SRC_T:    v = t_r;
        SRC_RHS:  v = rhs_r;
        SRC_U:    v = u_r;
        SRC_E:    v = e_r;
        SRC_F:    v = f_r;
        SRC_D:    v = d_r;
        default:  v = '0;
      endcase
      if (k == 0) opa = v;
      else        opb = v;
    end
  end

  // saturating add/subtract, operands already within the limit
  always_comb begin
    if (uop.op == OP_SUB) sum = {opa[IW-1], opa} - {opb[IW-1], opb};
    else                  sum = {opa[IW-1], opa} + {opb[IW-1], opb};
    if (sum > 65'(LIM))       alu_res = LIM;
    else if (sum < -65'(LIM)) alu_res = -LIM;
    else                      alu_res = sum[IW-1:0];
  end

  cfbq_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(opa), .b(opb),
    .done(mul_done), .res(mul_res)
  );

  cfbq_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .n(opa), .d(opb),
    .done(div_done), .res(div_res)
  );

  always_comb begin
    if (u_r > OUT_HI)      u_sat = SAMPLE_WIDTH'(OUT_HI);
    else if (u_r < OUT_LO) u_sat = SAMPLE_WIDTH'(OUT_LO);
    else                   u_sat = u_r[SAMPLE_WIDTH-1:0];
  end

  always_comb begin
    logic adv;
    adv       = 1'b0;
    state_nxt = state_r;
    pc_nxt    = pc_r;
    iter_nxt  = iter_r;
    mul_start = 1'b0;
    div_start = 1'b0;
    wr_en     = 1'b0;
    wr_val    = alu_res;
    take_in   = 1'b0;
    emit      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          take_in   = 1'b1;
          pc_nxt    = '0;
          iter_nxt  = '0;
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        case (uop.op)
          OP_MUL: begin
            mul_start = 1'b1;
            state_nxt = ST_MWAIT;
          end
          OP_DIV: begin
            div_start = 1'b1;
            state_nxt = ST_DWAIT;
          end
          default: begin
            wr_en = 1'b1;
            adv   = 1'b1;
          end
        endcase
      end
      ST_MWAIT: begin
        if (mul_done) begin
          wr_en  = 1'b1;
          wr_val = mul_res;
          adv    = 1'b1;
        end
      end
      ST_DWAIT: begin
        if (div_done) begin
          wr_en  = 1'b1;
          wr_val = div_res;
          adv    = 1'b1;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (adv) begin
      state_nxt = ST_ISSUE;
      if (pc_r == LAST_PC) begin
        if (iter_r == ITER_LAST) begin
          state_nxt = ST_FINISH;
        end else begin
          iter_nxt = iter_r + 1'b1;
          pc_nxt   = LOOP_PC;
        end
      end else begin
        pc_nxt = pc_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= '0;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
      p1_r        <= '0;
      p2_r        <= '0;
      q1_r        <= '0;
      q2_r        <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      iter_r  <= iter_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
        p2_r        <= p1_r;
        p1_r        <= x0_r;
        q2_r        <= q1_r;
        q1_r        <= u_sat;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      x0_r <= in_sample;
      c_r[0] <= mask_r[5] ? sig_b0  : coef_r[0];
      c_r[1] <= mask_r[4] ? sig_b1  : coef_r[1];
      c_r[2] <= mask_r[3] ? sig_b2  : coef_r[2];
      c_r[3] <= mask_r[2] ? sig_a1  : coef_r[3];
      c_r[4] <= mask_r[1] ? sig_a2  : coef_r[4];
      c_r[5] <= mask_r[0] ? sig_eps : coef_r[5];
    end
    if (emit) begin
      out_r <= u_sat;
    end
    if (wr_en) begin
      case (uop.dst)
        DST_S:   s_r   <= wr_val;
        DST_T:   t_r   <= wr_val;
        DST_RHS: rhs_r <= wr_val;
        DST_U:   u_r   <= wr_val;
        DST_E:   e_r   <= wr_val;
        DST_F:   f_r   <= wr_val;
        DST_D:   d_r   <= wr_val;
        default: t_r   <= wr_val;
      endcase
    end
  end

  assign in_ready   = (state_r == ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_sample = out_r;

  a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_ISSUE && pc_r == '0))
    else $error("accepted word did not start the sequence");

  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result raised outside finish");

  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (iter_r <= ITER_LAST) && (pc_r <= LAST_PC))
    else $error("sequencer out of range");

  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_start && div_start) && !(mul_done && div_done))
    else $error("multiplier and divider active together");

endmodule

FILE: sim/cubic_feedback_biquad_filter_core_tb.sv
// self-checking testbench for the cubic feedback biquad filter core
module cubic_feedback_biquad_filter_core_tb;
  import cfbq_pkg::*;

  typedef struct {
    logic signed [31:0] smp;
    logic signed [31:0] b0, b1, b2, a1, a2, eps;
  } sample_word_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [31:0] in_sample, sig_b0, sig_b1, sig_b2, sig_a1, sig_a2, sig_eps;
  logic signed [31:0] out_sample;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [4:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;

  cubic_feedback_biquad_filter_core uut (.*);

  sample_word_t pending_words[$];
  logic signed [31:0] expected_samples[$];
  int fail_count;
  int idle_pct, stall_pct;
  logic in_took;

  // filter model: config copy and history
  logic signed [31:0] mdl_coef[6];
  logic [5:0] mdl_mask;
  logic signed [63:0] hist_x1, hist_x2, hist_y1, hist_y2;

  localparam logic signed [127:0] LIM_WIDE = 128'sh3fff_ffff_ffff_ffff;
  localparam logic signed [63:0] ONE_Q = 64'sd1 <<< 28;

  function automatic logic signed [63:0] clamp_wide(input logic signed [127:0] v);
    if (v > LIM_WIDE) return LIM;
    if (v < -LIM_WIDE) return -LIM;
    return v[63:0];
  endfunction

  function automatic logic signed [63:0] add_sat(input logic signed [63:0] a, b);
    logic signed [127:0] w;
    w = a;
    w = w + b;
    return clamp_wide(w);
  endfunction

  function automatic logic signed [63:0] sub_sat(input logic signed [63:0] a, b);
    logic signed [127:0] w;
    w = a;
    w = w - b;
    return clamp_wide(w);
  endfunction

  // product floored to fraction bits
  function automatic logic signed [63:0] mul_q(input logic signed [63:0] a, b);
    logic signed [127:0] wa, wb, p;
    wa = a;
    wb = b;
    p = wa * wb;
    return clamp_wide(p >>> 28);
  endfunction

  // quotient truncated toward zero
  function automatic logic signed [63:0] div_q(input logic signed [63:0] n, d);
    logic signed [127:0] wn, wd;
    wn = n;
    wn = wn <<< 28;
    wd = d;
    return clamp_wide(wn / wd);
  endfunction

  function automatic logic signed [31:0] filter_sample(input sample_word_t w);
    logic signed [63:0] c[6];
    logic signed [63:0] sig[6];
    logic signed [63:0] x0, s, e, rhs, u, eu2, f, d;
    sig[0] = w.b0; sig[1] = w.b1; sig[2] = w.b2;
    sig[3] = w.a1; sig[4] = w.a2; sig[5] = w.eps;
    for (int k = 0; k < 6; k++) c[k] = mdl_mask[5-k] ? sig[k] : 64'(mdl_coef[k]);
    x0 = w.smp;
    e = c[5];
    s = mul_q(c[0], x0);
    s = add_sat(s, mul_q(c[1], hist_x1));
    s = add_sat(s, mul_q(c[2], hist_x2));
    s = sub_sat(s, mul_q(c[3], hist_y1));
    s = sub_sat(s, mul_q(c[4], hist_y2));
    rhs = mul_q(add_sat(e, ONE_Q), s);
    u = s;
    for (int k = 0; k < 3; k++) begin
      eu2 = mul_q(e, mul_q(u, u));
      f = sub_sat(add_sat(u, mul_q(eu2, u)), rhs);
      d = add_sat(add_sat(add_sat(ONE_Q, eu2), eu2), eu2);
      // zero denominator leaves u as it is
      if (d != 0) u = sub_sat(u, div_q(f, d));
    end
    if (u > 64'sd2147483647) u = 64'sd2147483647;
    if (u < -64'sd2147483648) u = -64'sd2147483648;
    hist_x2 = hist_x1;
    hist_x1 = x0;
    hist_y2 = hist_y1;
    hist_y1 = u;
    return u[31:0];
  endfunction

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 8000000);
    $display("cubic_feedback_biquad_filter_core test failed");
    $finish;
  end

  // input driver
  always @(negedge clk) begin
    logic nv;
    nv = in_valid && !in_took;
    if (rst_n && !nv && pending_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
      sample_word_t w;
      w = pending_words.pop_front();
      in_sample <= w.smp;
      sig_b0 <= w.b0; sig_b1 <= w.b1; sig_b2 <= w.b2;
      sig_a1 <= w.a1; sig_a2 <= w.a2; sig_eps <= w.eps;
      nv = 1;
    end
    in_valid <= nv;
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // acceptance and result monitor
  always @(posedge clk) begin
    sample_word_t w;
    logic signed [31:0] want;
    in_took <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      w.smp = in_sample;
      w.b0 = sig_b0; w.b1 = sig_b1; w.b2 = sig_b2;
      w.a1 = sig_a1; w.a2 = sig_a2; w.eps = sig_eps;
      expected_samples.push_back(filter_sample(w));
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_samples.size() == 0) begin
        $error("unexpected word out_sample %0d", out_sample);
        fail_count++;
      end else begin
        want = expected_samples.pop_front();
        if (out_sample !== want) begin
          $error("out_sample expected %0d actual %0d", want, out_sample);
          fail_count++;
        end
      end
    end
  end

  task automatic cfg_write(input int idx, input logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_penable <= 0;
    cfg_paddr <= 5'(idx * 4); cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1;
    @(negedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    if (idx < 6) mdl_coef[idx] = val;
    else if (idx == int'(REG_MASK)) mdl_mask = val[5:0];
  endtask

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_valid || expected_samples.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_field();
    int m;
    m = $urandom_range(9);
    if (m < 4) return $urandom;
    if (m < 8) return $signed($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000;
    if (m == 8) return 32'sh7fff_ffff;
    return 32'sh8000_0000;
  endfunction

  function automatic sample_word_t rand_word();
    sample_word_t w;
    w.smp = rand_field();
    w.b0 = rand_field(); w.b1 = rand_field(); w.b2 = rand_field();
    w.a1 = rand_field(); w.a2 = rand_field(); w.eps = rand_field();
    return w;
  endfunction

  function automatic logic [31:0] small_coef();
    return $signed($urandom_range(0, 32'h1000_0000)) - 32'sh0800_0000;
  endfunction

  initial begin
    sample_word_t w;
    logic signed [31:0] edge_vals[4];
    fail_count = 0;
    idle_pct = 0; stall_pct = 0;
    rst_n = 0; in_valid = 0; out_ready = 0; in_took = 0;
    in_sample = 0; sig_b0 = 0; sig_b1 = 0; sig_b2 = 0;
    sig_a1 = 0; sig_a2 = 0; sig_eps = 0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = 0; cfg_pwdata = 0;
    mdl_coef[0] = 32'sh1000_0000;
    for (int k = 1; k < 6; k++) mdl_coef[k] = 0;
    mdl_mask = 0;
    hist_x1 = 0; hist_x2 = 0; hist_y1 = 0; hist_y2 = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: reset coefficients, then per-word coefficients at extremes
    edge_vals[0] = 32'sh7fff_ffff; edge_vals[1] = 32'sh8000_0000;
    edge_vals[2] = 0; edge_vals[3] = 32'sh1000_0000;
    for (int k = 0; k < 4; k++) begin
      w = '{edge_vals[k], 0, 0, 0, 0, 0, 0};
      pending_words.push_back(w);
    end
    wait_drained();
    cfg_write(int'(REG_MASK), 32'hffff_ffff);
    for (int k = 0; k < 16; k++) begin
      w.smp = edge_vals[k % 4];
      w.b0 = edge_vals[(k / 4) % 4]; w.b1 = edge_vals[k % 2];
      w.b2 = edge_vals[3 - k % 4]; w.a1 = edge_vals[(k + 1) % 4];
      w.a2 = edge_vals[(k + 2) % 4]; w.eps = edge_vals[(k / 2) % 4];
      pending_words.push_back(w);
    end
    // strong negative cubic weight on a unit sample
    w = '{32'sh1000_0000, 32'sh1000_0000, 0, 0, 0, 0, -32'sh0555_5555};
    pending_words.push_back(w);
    wait_drained();
    // register index beyond the map is ignored
    cfg_write(int'(REG_NONE), 32'h1234_5678);

    for (int p = 1; p <= 8; p++) begin
      case (p % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 61; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 61; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      for (int k = 0; k < 6; k++) begin
        if (p == 1) cfg_write(k, 32'h7fff_ffff);
        else if (p == 2) cfg_write(k, 32'h8000_0000);
        else if (p == 3) cfg_write(k, $urandom);
        else cfg_write(k, small_coef());
      end
      if (p == 3) cfg_write(int'(REG_MASK), 32'h0000_003f);
      else if (p <= 2) cfg_write(int'(REG_MASK), 32'h0000_0000);
      else cfg_write(int'(REG_MASK), $urandom);
      for (int i = 0; i < 210; i++) pending_words.push_back(rand_word());
      // sender holds off until every expected word is back
      wait_drained();
    end

    repeat (600) @(posedge clk);
    if (fail_count == 0 && expected_samples.size() == 0)
      $display("cubic_feedback_biquad_filter_core test passed");
    else
      $display("cubic_feedback_biquad_filter_core test failed");
    $finish;
  end

endmodule
